// File: hdl/cas_pkg.sv
// Package with the shared constants and types of the column statistics block.
package cas_pkg;

  localparam int MAX_COLS       = 16;
  localparam int MAX_ROWS       = 65536;
  localparam int DISTINCT_DEPTH = 256;

  localparam int COL_W  = 4;
  localparam int VAL_W  = 32;
  localparam int SUM_W  = 48;
  localparam int CNT_W  = 17;
  localparam int DCNT_W = 9;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [ADDR_W-1:0] REG_COLUMN_SELECT = 3'd0;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [SUM_W-1:0] SUM_HI  = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [SUM_W-1:0] SUM_LO  = 48'sh8000_0000_0000;

  typedef struct packed {
    logic                    vld;
    logic signed [VAL_W-1:0] value;
  } cand_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] maxv;
    logic signed [VAL_W-1:0] minv;
  } stats_t;

  typedef struct packed {
    logic [DCNT_W-1:0] used;
    logic              ovf;
  } dstat_t;

endpackage

// File: hdl/cas_ifs.sv
// Valid/ready channel interfaces for cells in and statistics out.
interface cas_in_if import cas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [COL_W-1:0]        column_index;
  logic signed [VAL_W-1:0] cell_value;
  logic                    missing;
  logic                    last;

  modport source (output valid, column_index, cell_value, missing, last, input ready);
  modport sink (input valid, column_index, cell_value, missing, last, output ready);
endinterface

interface cas_out_if import cas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [SUM_W-1:0] total;
  logic [CNT_W-1:0]        present_count;
  logic signed [VAL_W-1:0] largest;
  logic signed [VAL_W-1:0] smallest;
  logic [DCNT_W-1:0]       distinct_count;
  logic                    distinct_overflow;
  logic                    column_empty;

  modport source (output valid, total, present_count, largest, smallest, distinct_count,
                  distinct_overflow, column_empty, input ready);
  modport sink (input valid, total, present_count, largest, smallest, distinct_count,
                distinct_overflow, column_empty, output ready);
endinterface

// File: hdl/cas_cell.sv
// One cell of the distinct-value chain: a stored value and a candidate in flight.
module cas_cell import cas_pkg::*; #(
  parameter int CELL_IDX = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cand_t             cand_in,
  input  logic [DCNT_W-1:0] used,
  output cand_t             cand_out,
  output logic              fill
);

  cand_t                   cand_r;
  logic signed [VAL_W-1:0] stored_r;
  logic                    occupied;
  logic                    front;
  logic                    match;

  assign occupied = used > DCNT_W'(CELL_IDX);
  assign front    = used == DCNT_W'(CELL_IDX);
  assign match    = occupied && (stored_r == cand_r.value);
  assign fill     = cand_r.vld && front;

  assign cand_out.vld   = cand_r.vld && !match && !front;
  assign cand_out.value = cand_r.value;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cand_r.vld <= 1'b0;
    end else begin
      cand_r.vld <= cand_in.vld;
    end
    cand_r.value <= cand_in.value;
    if (fill) begin
      stored_r <= cand_r.value;
    end
  end

endmodule

// File: hdl/cas_chain.sv
// Row of distinct-value cells with the fill count and the overflow flag.
module cas_chain import cas_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  cand_t  cand_in,
  input  logic   clear,
  output dstat_t dstat
);

  cand_t                     link [DISTINCT_DEPTH+1];
  logic [DISTINCT_DEPTH-1:0] fill;
  logic [DCNT_W-1:0]         used_r;
  logic [DCNT_W-1:0]         used_nxt;
  logic                      ovf_r;
  logic                      ovf_nxt;

  assign link[0] = cand_in;

  for (genvar k = 0; k < DISTINCT_DEPTH; k++) begin : g_cell
    cas_cell #(.CELL_IDX(k)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cand_in  (link[k]),
      .used     (used_r),
      .cand_out (link[k+1]),
      .fill     (fill[k])
    );
  end

  always_comb begin
    used_nxt = used_r;
    ovf_nxt  = ovf_r;
    if (clear) begin
      used_nxt = '0;
      ovf_nxt  = 1'b0;
    end else begin
      if (|fill) begin
        used_nxt = used_r + 1'b1;
      end
      if (link[DISTINCT_DEPTH].vld) begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      ovf_r  <= ovf_nxt;
    end
  end

  assign dstat.used = used_r;
  assign dstat.ovf  = ovf_r;

`ifndef SYNTHESIS
  a_used_bound: assert property (@(posedge clk) disable iff (!rst_n)
    used_r <= DCNT_W'(DISTINCT_DEPTH))
    else $error("distinct fill count beyond store depth");

  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> used_r == DCNT_W'(DISTINCT_DEPTH))
    else $error("overflow flagged while the store has room");

  a_one_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(fill))
    else $error("more than one cell filled in a cycle");
`endif

endmodule

// File: hdl/cas_accum.sv
// Running sum, present count, maximum and minimum of the selected column.
module cas_accum import cas_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    take,
  input  logic signed [VAL_W-1:0] value,
  input  logic                    clear,
  output stats_t                  stats
);

  stats_t                  st_r;
  stats_t                  st_nxt;
  logic signed [SUM_W:0]   sum_ext;

  assign sum_ext = {st_r.sum[SUM_W-1], st_r.sum}
                 + {{(SUM_W+1-VAL_W){value[VAL_W-1]}}, value};

  always_comb begin
    st_nxt = st_r;
    if (clear) begin
      st_nxt.sum   = '0;
      st_nxt.count = '0;
      st_nxt.maxv  = VAL_MIN;
      st_nxt.minv  = VAL_MAX;
    end else if (take) begin
      if (sum_ext[SUM_W] != sum_ext[SUM_W-1]) begin
        st_nxt.sum = sum_ext[SUM_W] ? SUM_LO : SUM_HI;
      end else begin
        st_nxt.sum = sum_ext[SUM_W-1:0];
      end
      if (st_r.count < CNT_W'(MAX_ROWS)) begin
        st_nxt.count = st_r.count + 1'b1;
      end
      if (value > st_r.maxv) begin
        st_nxt.maxv = value;
      end
      if (value < st_r.minv) begin
        st_nxt.minv = value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.sum   <= '0;
      st_r.count <= '0;
      st_r.maxv  <= VAL_MIN;
      st_r.minv  <= VAL_MAX;
    end else begin
      st_r <= st_nxt;
    end
  end

  assign stats = st_r;

endmodule

// File: hdl/column_aggregate_stats_top.sv
// Top level of the column statistics block: ports, register, drain control, result register.
//
//   channel   direction  handshake              carries
//   in_ch     in         valid/ready            column_index, cell_value, missing, last
//   out_ch    out        valid/ready            total, counts, largest, smallest, flags
//   APB       in/out     psel/penable/pready    column_select at byte address 0
//
// Cells are taken one per cycle while a table streams in.
// After the last cell the input stalls while its value travels down the 256-cell distinct
// chain; the result then loads the output register.
// If the previous result has not been taken yet, the drain waits for the output register.
// Reset is synchronous and clears control, statistics and the distinct fill count.
module column_aggregate_stats_top import cas_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  cas_in_if.sink            in_ch,
  cas_out_if.source         out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [COL_W-1:0]        sel_r;
  logic                    pend_r;
  logic [DCNT_W-1:0]       drain_r;
  logic                    out_valid_r;
  logic signed [SUM_W-1:0] total_r;
  logic [CNT_W-1:0]        count_r;
  logic signed [VAL_W-1:0] largest_r;
  logic signed [VAL_W-1:0] smallest_r;
  logic [DCNT_W-1:0]       dcount_r;
  logic                    dovf_r;
  logic                    accept;
  logic                    take;
  logic                    capture;
  cand_t                   cand;
  stats_t                  stats;
  dstat_t                  dstat;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_COLUMN_SELECT) ? DATA_W'(sel_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sel_r <= '0;
    end else if (psel && penable && pwrite && paddr == REG_COLUMN_SELECT) begin
      sel_r <= pwdata[COL_W-1:0];
    end
  end

  assign in_ch.ready = !pend_r;
  assign accept      = in_ch.valid && !pend_r;
  assign take        = accept && !in_ch.missing && in_ch.column_index == sel_r
                       && (32'(in_ch.column_index) < MAX_COLS);
  assign capture     = pend_r && drain_r == '0 && (!out_valid_r || out_ch.ready);

  assign cand.vld   = take;
  assign cand.value = in_ch.cell_value;

  cas_accum u_accum (
    .clk   (clk),
    .rst_n (rst_n),
    .take  (take),
    .value (in_ch.cell_value),
    .clear (capture),
    .stats (stats)
  );

  cas_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .cand_in (cand),
    .clear   (capture),
    .dstat   (dstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r      <= 1'b0;
      drain_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept && in_ch.last) begin
        pend_r  <= 1'b1;
        drain_r <= DCNT_W'(DISTINCT_DEPTH);
      end else if (capture) begin
        pend_r <= 1'b0;
      end else if (drain_r != '0) begin
        drain_r <= drain_r - 1'b1;
      end
      if (capture) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      total_r    <= stats.sum;
      count_r    <= stats.count;
      largest_r  <= stats.maxv;
      smallest_r <= stats.minv;
      dcount_r   <= dstat.used;
      dovf_r     <= dstat.ovf;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.total             = total_r;
  assign out_ch.present_count     = count_r;
  assign out_ch.largest           = largest_r;
  assign out_ch.smallest          = smallest_r;
  assign out_ch.distinct_count    = dcount_r;
  assign out_ch.distinct_overflow = dovf_r;
  assign out_ch.column_empty      = (count_r == '0);

`ifndef SYNTHESIS
  a_drain_pend: assert property (@(posedge clk) disable iff (!rst_n)
    (drain_r != '0) |-> pend_r)
    else $error("drain counter running without a pending table");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_ch.column_empty) |-> (dcount_r == '0 && !dovf_r))
    else $error("empty column reported with distinct values");

  a_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.column_empty) |-> (largest_r >= smallest_r))
    else $error("maximum below minimum in a non-empty result");
`endif

endmodule
